// ===== src/hcfp_pkg.sv =====
// Shared types, constants and the hex digit decoder for the command frame parser.
package hcfp_pkg;

  localparam int ARG_DIGITS = 4;
  localparam int FRAME_LEN  = 4 + 2 * ARG_DIGITS;
  localparam int POS_W      = $clog2(FRAME_LEN + 2);
  localparam int ARG_W      = 16;
  localparam int FLAG_W     = 3;

  localparam logic [POS_W-1:0] POS_ACTION  = '0;
  localparam logic [POS_W-1:0] POS_SUBJECT = POS_W'(1);
  localparam logic [POS_W-1:0] POS_PARAM   = POS_W'(2);
  localparam logic [POS_W-1:0] POS_ARG2    = POS_W'(3 + ARG_DIGITS);
  localparam logic [POS_W-1:0] POS_TERM    = POS_W'(3 + 2 * ARG_DIGITS);
  localparam logic [POS_W-1:0] POS_FRAME   = POS_W'(FRAME_LEN);
  localparam logic [POS_W-1:0] POS_SAT     = POS_W'(FRAME_LEN + 1);

  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UF   = 8'h46;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LF   = 8'h66;
  localparam logic [7:0] HEX_TEN = 8'd10;

  localparam int ERR_LEN  = 0;
  localparam int ERR_TERM = 1;
  localparam int ERR_HEX  = 2;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_LENGTH = 2'd1,
    ST_TERM   = 2'd2,
    ST_HEX    = 2'd3
  } status_e;

  typedef struct packed {
    op_e        operation;
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]        action_code;
    logic [7:0]        subject_code;
    logic [7:0]        param_code;
    logic [ARG_W-1:0]  first_argument;
    logic [ARG_W-1:0]  second_argument;
    status_e           status;
    logic [FLAG_W-1:0] error_flags;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = '0;
    if (c >= CH_0 && c <= CH_9) begin
      h.val = 4'(c - CH_0);
    end else if (c >= CH_UA && c <= CH_UF) begin
      h.val = 4'(c - CH_UA + HEX_TEN);
    end else if (c >= CH_LA && c <= CH_LF) begin
      h.val = 4'(c - CH_LA + HEX_TEN);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// ===== src/hcfp_if.sv =====
// Valid/ready channel interfaces for frame bytes in and decoded commands out.
interface hcfp_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output operation, output data_byte, output last_byte,
                  input ready);
  modport sink (input valid, input operation, input data_byte, input last_byte,
                output ready);
endinterface

interface hcfp_out_if;
  logic                         valid;
  logic                         ready;
  logic [7:0]                   action_code;
  logic [7:0]                   subject_code;
  logic [7:0]                   param_code;
  logic [hcfp_pkg::ARG_W-1:0]   first_argument;
  logic [hcfp_pkg::ARG_W-1:0]   second_argument;
  logic [1:0]                   status;
  logic [hcfp_pkg::FLAG_W-1:0]  error_flags;

  modport source (output valid, output action_code, output subject_code, output param_code,
                  output first_argument, output second_argument, output status,
                  output error_flags, input ready);
  modport sink (input valid, input action_code, input subject_code, input param_code,
                input first_argument, input second_argument, input status,
                input error_flags, output ready);
endinterface

// ===== src/hcfp_in_reg.sv =====
// Input register stage: captures one item and holds it until the decoder takes it.
module hcfp_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  hcfp_pkg::item_t     item_i,
  output logic                valid_o,
  output hcfp_pkg::item_t     item_o,
  input  logic                take_i
);

  logic            valid_q, valid_d;
  hcfp_pkg::item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = (valid_i && ready_o) ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== src/hcfp_decode.sv =====
// Frame state, argument accumulation, status checks and the result register.
module hcfp_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  hcfp_pkg::item_t     item_i,
  output logic                take_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hcfp_pkg::result_t   result_o
);

  logic [hcfp_pkg::POS_W-1:0]  pos_q, pos_d, pos_nx;
  logic [7:0]                  action_q, action_d;
  logic [7:0]                  subject_q, subject_d;
  logic [7:0]                  param_q, param_d;
  logic [hcfp_pkg::ARG_W-1:0]  arg1_q, arg1_d;
  logic [hcfp_pkg::ARG_W-1:0]  arg2_q, arg2_d;
  logic                        bad_q, bad_d;
  logic [hcfp_pkg::FLAG_W-1:0] sticky_q, sticky_d;
  logic                        out_valid_q, out_valid_d;
  hcfp_pkg::result_t           res_q, res_d;
  hcfp_pkg::hex_t              hex;
  hcfp_pkg::status_e           status;
  logic                        ends_frame;
  logic                        out_free;
  logic [hcfp_pkg::ARG_W-1:0]  arg1_nx, arg2_nx;
  logic                        bad_nx;
  logic [7:0]                  action_nx, subject_nx, param_nx;

  assign hex        = hcfp_pkg::hex_decode(item_i.data_byte);
  assign ends_frame = (item_i.operation == hcfp_pkg::OP_PUSH) && item_i.last_byte;
  assign out_free   = !out_valid_q || out_ready_i;
  assign take_o     = item_valid_i && (!ends_frame || out_free);

  always_comb begin
    action_nx  = action_q;
    subject_nx = subject_q;
    param_nx   = param_q;
    arg1_nx    = arg1_q;
    arg2_nx    = arg2_q;
    bad_nx     = bad_q;
    if (pos_q == hcfp_pkg::POS_ACTION) begin
      action_nx = item_i.data_byte;
    end else if (pos_q == hcfp_pkg::POS_SUBJECT) begin
      subject_nx = item_i.data_byte;
    end else if (pos_q == hcfp_pkg::POS_PARAM) begin
      param_nx = item_i.data_byte;
    end else if (pos_q < hcfp_pkg::POS_ARG2) begin
      // a bad digit shifts in as zero
      arg1_nx = {arg1_q[hcfp_pkg::ARG_W-5:0], hex.val};
      bad_nx  = bad_q | !hex.ok;
    end else if (pos_q < hcfp_pkg::POS_TERM) begin
      arg2_nx = {arg2_q[hcfp_pkg::ARG_W-5:0], hex.val};
      bad_nx  = bad_q | !hex.ok;
    end
    // saturate one past the frame length
    pos_nx = (pos_q <= hcfp_pkg::POS_FRAME) ? pos_q + hcfp_pkg::POS_W'(1) : pos_q;

    if (pos_nx != hcfp_pkg::POS_FRAME) begin
      status = hcfp_pkg::ST_LENGTH;
    end else if (item_i.data_byte != hcfp_pkg::CH_BANG) begin
      status = hcfp_pkg::ST_TERM;
    end else if (bad_nx) begin
      status = hcfp_pkg::ST_HEX;
    end else begin
      status = hcfp_pkg::ST_OK;
    end
  end

  always_comb begin
    pos_d       = pos_q;
    action_d    = action_q;
    subject_d   = subject_q;
    param_d     = param_q;
    arg1_d      = arg1_q;
    arg2_d      = arg2_q;
    bad_d       = bad_q;
    sticky_d    = sticky_q;
    res_d       = res_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;

    if (take_o) begin
      if (item_i.operation == hcfp_pkg::OP_CLEAR) begin
        sticky_d = '0;
      end else if (!item_i.last_byte) begin
        pos_d     = pos_nx;
        action_d  = action_nx;
        subject_d = subject_nx;
        param_d   = param_nx;
        arg1_d    = arg1_nx;
        arg2_d    = arg2_nx;
        bad_d     = bad_nx;
      end else begin
        case (status)
          hcfp_pkg::ST_LENGTH: sticky_d[hcfp_pkg::ERR_LEN]  = 1'b1;
          hcfp_pkg::ST_TERM:   sticky_d[hcfp_pkg::ERR_TERM] = 1'b1;
          hcfp_pkg::ST_HEX:    sticky_d[hcfp_pkg::ERR_HEX]  = 1'b1;
          default:             sticky_d = sticky_q;
        endcase
        if (status == hcfp_pkg::ST_LENGTH || status == hcfp_pkg::ST_TERM) begin
          res_d.action_code  = '0;
          res_d.subject_code = '0;
          res_d.param_code   = '0;
        end else begin
          res_d.action_code  = action_nx;
          res_d.subject_code = subject_nx;
          res_d.param_code   = param_nx;
        end
        res_d.first_argument  = (status == hcfp_pkg::ST_OK) ? arg1_nx : '0;
        res_d.second_argument = (status == hcfp_pkg::ST_OK) ? arg2_nx : '0;
        res_d.status          = status;
        res_d.error_flags     = sticky_d;
        out_valid_d           = 1'b1;
        // drop all frame state, keep the sticky flags
        pos_d     = '0;
        action_d  = '0;
        subject_d = '0;
        param_d   = '0;
        arg1_d    = '0;
        arg2_d    = '0;
        bad_d     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      action_q    <= '0;
      subject_q   <= '0;
      param_q     <= '0;
      arg1_q      <= '0;
      arg2_q      <= '0;
      bad_q       <= 1'b0;
      sticky_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      action_q    <= action_d;
      subject_q   <= subject_d;
      param_q     <= param_d;
      arg1_q      <= arg1_d;
      arg2_q      <= arg2_d;
      bad_q       <= bad_d;
      sticky_q    <= sticky_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= hcfp_pkg::POS_SAT)
    else $error("byte position ran past saturation");

  a_frame_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && ends_frame |=> pos_q == '0 && !bad_q)
    else $error("frame state not cleared after a result");

  a_clear_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && item_i.operation == hcfp_pkg::OP_CLEAR |=> sticky_q == '0)
    else $error("clear item left sticky flags set");

  a_err_args_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.status != hcfp_pkg::ST_OK |->
      res_q.first_argument == '0 && res_q.second_argument == '0)
    else $error("arguments nonzero on an error result");

  a_len_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.status == hcfp_pkg::ST_LENGTH |->
      res_q.error_flags[hcfp_pkg::ERR_LEN])
    else $error("length error without its sticky flag");

endmodule

// ===== src/hex_command_frame_parser.sv =====
// Top level of the hex command frame parser.
// Takes one frame byte per item (or a clear item for the sticky flags) and, on the byte
// marked last, gives one result with the action, subject and param bytes, the two
// decoded hex arguments, a status and the sticky error flags. A frame is
// 4 + 2*ARG_DIGITS bytes (12 by default) ending in '!'. An accepted item sits in the
// input register until the decode logic takes it, and the result register loads as
// the last byte is taken. One item is accepted every cycle while the result register
// drains; only a last byte waits on a full, stalled result register, and it holds off
// the input until the result is taken.
module hex_command_frame_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  hcfp_in_if.sink    in_i,
  hcfp_out_if.source out_o
);

  hcfp_pkg::item_t   in_item;
  hcfp_pkg::item_t   reg_item;
  hcfp_pkg::result_t result;
  logic              reg_valid;
  logic              take;

  assign in_item.operation = hcfp_pkg::op_e'(in_i.operation);
  assign in_item.data_byte = in_i.data_byte;
  assign in_item.last_byte = in_i.last_byte;

  hcfp_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .item_i  (in_item),
    .valid_o (reg_valid),
    .item_o  (reg_item),
    .take_i  (take)
  );

  hcfp_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (reg_valid),
    .item_i       (reg_item),
    .take_o       (take),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .result_o     (result)
  );

  assign out_o.action_code     = result.action_code;
  assign out_o.subject_code    = result.subject_code;
  assign out_o.param_code      = result.param_code;
  assign out_o.first_argument  = result.first_argument;
  assign out_o.second_argument = result.second_argument;
  assign out_o.status          = result.status;
  assign out_o.error_flags     = result.error_flags;

endmodule

// ===== tb/hex_command_frame_parser_tb.sv =====
// Self-checking testbench for the hex command frame parser: random frames against a predictor.
import hcfp_pkg::*;

typedef logic [7:0] frame_bytes_t[$];

// Return 1 when c is a hex digit and give its value in nib.
function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] nib);
  nib = c[3:0] + ((c > CH_9) ? 4'd9 : 4'd0);
  return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF);
endfunction

class frame_scoreboard;
  logic [POS_W-1:0]  taken;
  logic [7:0]        action_q;
  logic [7:0]        subject_q;
  logic [7:0]        param_q;
  logic [ARG_W-1:0]  arg_a;
  logic [ARG_W-1:0]  arg_b;
  logic              digit_bad;
  logic [FLAG_W-1:0] sticky;
  result_t           awaited[$];
  int                errors;
  int                clears;
  int                status_count[4];

  function new();
    wipe_frame();
    sticky = '0;
    errors = 0;
    clears = 0;
    foreach (status_count[k]) status_count[k] = 0;
  endfunction

  function void wipe_frame();
    taken     = '0;
    action_q  = '0;
    subject_q = '0;
    param_q   = '0;
    arg_a     = '0;
    arg_b     = '0;
    digit_bad = 1'b0;
  endfunction

  // Bad digits shift in as zero and mark the frame.
  function logic [ARG_W-1:0] shift_digit(logic [ARG_W-1:0] acc, logic [7:0] c);
    logic [3:0] nib;
    if (!hex_digit(c, nib)) begin
      digit_bad = 1'b1;
      nib = '0;
    end
    return {acc[ARG_W-5:0], nib};
  endfunction

  function void note_item(item_t it);
    result_t r;
    if (it.operation == OP_CLEAR) begin
      sticky = '0;
      clears++;
      return;
    end
    if (taken < POS_FRAME) begin
      if (taken == POS_ACTION) action_q = it.data_byte;
      else if (taken == POS_SUBJECT) subject_q = it.data_byte;
      else if (taken == POS_PARAM) param_q = it.data_byte;
      else if (taken < POS_ARG2) arg_a = shift_digit(arg_a, it.data_byte);
      else if (taken < POS_TERM) arg_b = shift_digit(arg_b, it.data_byte);
    end
    if (taken <= POS_FRAME) taken = taken + 1'b1;
    if (!it.last_byte) return;

    r = '0;
    if (taken != POS_FRAME) begin
      r.status = ST_LENGTH;
      sticky[ERR_LEN] = 1'b1;
    end else if (it.data_byte != CH_BANG) begin
      r.status = ST_TERM;
      sticky[ERR_TERM] = 1'b1;
    end else if (digit_bad) begin
      r.status = ST_HEX;
      sticky[ERR_HEX] = 1'b1;
    end else begin
      r.status = ST_OK;
    end
    if (r.status == ST_OK || r.status == ST_HEX) begin
      r.action_code  = action_q;
      r.subject_code = subject_q;
      r.param_code   = param_q;
    end
    if (r.status == ST_OK) begin
      r.first_argument  = arg_a;
      r.second_argument = arg_b;
    end
    r.error_flags = sticky;
    awaited.push_back(r);
    wipe_frame();
  endfunction

  function void compare_field(string name, logic [ARG_W-1:0] want, logic [ARG_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_result(result_t got);
    result_t want;
    if (awaited.size() == 0) begin
      $display("%0t: unexpected result, expected none, got %h", $time, got);
      errors++;
      return;
    end
    want = awaited.pop_front();
    status_count[want.status]++;
    compare_field("action_code", ARG_W'(want.action_code), ARG_W'(got.action_code));
    compare_field("subject_code", ARG_W'(want.subject_code), ARG_W'(got.subject_code));
    compare_field("param_code", ARG_W'(want.param_code), ARG_W'(got.param_code));
    compare_field("first_argument", want.first_argument, got.first_argument);
    compare_field("second_argument", want.second_argument, got.second_argument);
    compare_field("status", ARG_W'(want.status), ARG_W'(got.status));
    compare_field("error_flags", ARG_W'(want.error_flags), ARG_W'(got.error_flags));
  endfunction
endclass

module hex_command_frame_parser_tb;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 800;
  localparam logic [7:0] NEAR_HEX [8] = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67,
                                          CH_9, CH_LA};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit   steady = 1'b0;
  int   cycles = 0;
  int   pushed = 0;

  hcfp_in_if  in_bus ();
  hcfp_out_if out_bus ();

  hex_command_frame_parser u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  frame_scoreboard board = new();

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, board.awaited.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Stall the result side at random, except during the steady stretch.
  always @(negedge clk_i) begin
    out_bus.ready = steady || ($urandom_range(99) >= 28);
  end

  always @(posedge clk_i) begin
    result_t seen;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      seen.action_code     = out_bus.action_code;
      seen.subject_code    = out_bus.subject_code;
      seen.param_code      = out_bus.param_code;
      seen.first_argument  = out_bus.first_argument;
      seen.second_argument = out_bus.second_argument;
      seen.status          = status_e'(out_bus.status);
      seen.error_flags     = out_bus.error_flags;
      board.check_result(seen);
    end
  end

  function automatic logic [7:0] hex_char(logic [3:0] v, bit lower);
    if (v < 4'd10) return CH_0 + 8'(v);
    return (lower ? CH_LA : CH_UA) + 8'(v) - HEX_TEN;
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    logic [3:0] nib;
    c = 8'($urandom);
    while (hex_digit(c, nib)) c = 8'($urandom);
    return c;
  endfunction

  function automatic frame_bytes_t well_formed();
    frame_bytes_t f;
    repeat (3) f.push_back(8'($urandom));
    repeat (2 * ARG_DIGITS) f.push_back(hex_char(4'($urandom), 1'($urandom)));
    f.push_back(CH_BANG);
    return f;
  endfunction

  // Present one item at the falling edge and hold it until accepted.
  task automatic push_item(op_e op, logic [7:0] data, logic last);
    item_t it;
    it.operation = op;
    it.data_byte = data;
    it.last_byte = last;
    while (!steady && $urandom_range(99) < 28) begin
      in_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid     = 1'b1;
    in_bus.operation = op;
    in_bus.data_byte = data;
    in_bus.last_byte = last;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    board.note_item(it);
    pushed++;
    @(negedge clk_i);
  endtask

  task automatic send_frame(frame_bytes_t f);
    foreach (f[k]) begin
      if ($urandom_range(99) < 3) push_item(OP_CLEAR, 8'($urandom), 1'($urandom));
      push_item(OP_PUSH, f[k], k == f.size() - 1);
    end
  endtask

  initial begin
    frame_bytes_t f;
    int pick;
    in_bus.valid     = 1'b0;
    in_bus.operation = OP_PUSH;
    in_bus.data_byte = '0;
    in_bus.last_byte = 1'b0;
    out_bus.ready    = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Good frame with extreme codes and arguments of all ones and all zeros.
    f = '{8'h00, 8'hFF, 8'h80};
    for (int k = 0; k < ARG_DIGITS; k++) f.push_back(hex_char(4'hF, k[0]));
    for (int k = 0; k < ARG_DIGITS; k++) f.push_back(hex_char(4'h0, k[0]));
    f.push_back(CH_BANG);
    send_frame(f);
    // One-byte frame: too short even though it is the terminator.
    push_item(OP_PUSH, CH_BANG, 1'b1);
    // Characters just outside each hex range, mixed with the edge digits '9' and 'a'.
    f = '{8'h53, 8'h54, 8'h55};
    for (int k = 0; k < 2 * ARG_DIGITS; k++) f.push_back(NEAR_HEX[k % 8]);
    f.push_back(CH_BANG);
    send_frame(f);
    push_item(OP_CLEAR, 8'hFF, 1'b1);

    while (pushed < RANDOM_ITEMS) begin
      steady = (pushed >= 300 && pushed < 450);
      f = well_formed();
      pick = $urandom_range(99);
      if (pick < 55) begin
        // keep it well formed
      end else if (pick < 65) begin
        repeat ($urandom_range(1, 2)) f[$urandom_range(3, 2 + 2 * ARG_DIGITS)] = junk_char();
      end else if (pick < 75) begin
        f[FRAME_LEN-1] = 8'($urandom);
        if (f[FRAME_LEN-1] == CH_BANG) f[FRAME_LEN-1] ^= 8'h01;
        if ($urandom_range(1)) f[3 + $urandom_range(2 * ARG_DIGITS - 1)] = junk_char();
      end else if (pick < 85) begin
        f = f[0:$urandom_range(FRAME_LEN-2)];
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 8)) f.push_back(8'($urandom));
      end else begin
        f.delete();
        repeat ($urandom_range(1, 16)) f.push_back(8'($urandom));
        if ($urandom_range(1)) f[f.size()-1] = CH_BANG;
      end
      send_frame(f);
    end
    steady = 1'b0;
    in_bus.valid = 1'b0;

    while (board.awaited.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Sent %0d items including %0d flag clears over %0d cycles.",
             pushed, board.clears, cycles);
    $display("Frames checked: %0d ok, %0d length, %0d terminator, %0d hex digit.",
             board.status_count[ST_OK], board.status_count[ST_LENGTH],
             board.status_count[ST_TERM], board.status_count[ST_HEX]);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
src/hcfp_pkg.sv
src/hcfp_if.sv
src/hcfp_in_reg.sv
src/hcfp_decode.sv
src/hex_command_frame_parser.sv
tb/hex_command_frame_parser_tb.sv
